FILE: src/nlmsanc_pkg.sv
// Shared types, register codes and fixed widths of the NLMS noise canceller.
package nlmsanc_pkg;

   localparam int MAX_TAPS_DEF = 32;
   localparam int DATA_W       = 32;
   localparam int GAIN_W       = 15;
   localparam int TAPS_W       = 6;
   localparam int QSAT_W       = 64;
   localparam int PROD_SHIFT   = 28;
   localparam int GAIN_SHIFT   = 45;
   localparam int UPD_SHIFT    = 31;
   localparam int DELTA_W      = 34;

   localparam logic [1:0] CSR_TAPS  = 2'd0;
   localparam logic [1:0] CSR_GAIN  = 2'd1;
   localparam logic [1:0] CSR_FLOOR = 2'd2;

   localparam logic [TAPS_W-1:0] TAPS_RST  = 6'd32;
   localparam logic [GAIN_W-1:0] GAIN_RST  = 15'd1638;
   localparam logic [DATA_W-1:0] FLOOR_RST = 32'd1048576;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAC,
      S_MAC_DRAIN,
      S_ERR,
      S_EMIT,
      S_DIV,
      S_UPD,
      S_UPD_DRAIN
   } state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic mac;
      logic err;
      logic emit;
      logic div_step;
      logic upd;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic energy_zero;
   } sts_type;

endpackage

FILE: src/nlmsanc_ctrl.sv
// Sequencer that walks one word through filter, divide and weight update passes.
module nlmsanc_ctrl #(
   parameter int IDX_W = 5,
   parameter int NUM_W = 103
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [IDX_W-1:0]     taps_last,
   input  nlmsanc_pkg::sts_type sts,
   output nlmsanc_pkg::cmd_type cmd,
   output logic [IDX_W-1:0]     idx
);

   localparam int DCNT_W = $clog2(NUM_W);

   nlmsanc_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nlmsanc_pkg::S_IDLE;
         idx_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         dcnt_ff  <= dcnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      dcnt_in  = dcnt_ff;
      unique case (state_ff)
         nlmsanc_pkg::S_IDLE: begin
            idx_in = '0;
            if (req_tvalid) state_in = nlmsanc_pkg::S_MAC;
         end
         nlmsanc_pkg::S_MAC: begin
            if (idx_ff == taps_last) begin
               idx_in   = '0;
               state_in = nlmsanc_pkg::S_MAC_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         nlmsanc_pkg::S_MAC_DRAIN: state_in = nlmsanc_pkg::S_ERR;
         nlmsanc_pkg::S_ERR:       state_in = nlmsanc_pkg::S_EMIT;
         nlmsanc_pkg::S_EMIT: begin
            dcnt_in = '0;
            if (sts.slot_free) begin
               state_in = sts.energy_zero ? nlmsanc_pkg::S_IDLE : nlmsanc_pkg::S_DIV;
            end
         end
         nlmsanc_pkg::S_DIV: begin
            if (dcnt_ff == DCNT_W'(NUM_W - 1)) begin
               idx_in   = '0;
               state_in = nlmsanc_pkg::S_UPD;
            end else begin
               dcnt_in = dcnt_ff + 1'b1;
            end
         end
         nlmsanc_pkg::S_UPD: begin
            if (idx_ff == taps_last) begin
               idx_in   = '0;
               state_in = nlmsanc_pkg::S_UPD_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         nlmsanc_pkg::S_UPD_DRAIN: state_in = nlmsanc_pkg::S_IDLE;
         default:                  state_in = nlmsanc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         nlmsanc_pkg::S_IDLE: begin
            cmd.ready = 1'b1;
            cmd.load  = req_tvalid;
         end
         nlmsanc_pkg::S_MAC:  cmd.mac      = 1'b1;
         nlmsanc_pkg::S_ERR:  cmd.err      = 1'b1;
         nlmsanc_pkg::S_EMIT: cmd.emit     = sts.slot_free;
         nlmsanc_pkg::S_DIV:  cmd.div_step = 1'b1;
         nlmsanc_pkg::S_UPD:  cmd.upd      = 1'b1;
         default:             cmd          = '0;
      endcase
   end

   assign idx = idx_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free) else $error("result emitted over a full slot");
   a_mac_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mac || cmd.upd) |-> (idx_ff <= taps_last)) else $error("tap index overrun");
   a_load_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == nlmsanc_pkg::S_MAC)) else $error("load did not start pass");

endmodule

FILE: src/nlmsanc_dp.sv
// Datapath: delay line, weights, accumulators, serial divider and output register.
module nlmsanc_dp #(
   parameter int MAX_TAPS = nlmsanc_pkg::MAX_TAPS_DEF,
   parameter int IDX_W    = 5,
   parameter int ACC_W    = 70,
   parameter int EN_W     = 68,
   parameter int E_W      = 43,
   parameter int NUM_W    = 103
) (
   input  logic                            clock,
   input  logic                            reset,
   input  nlmsanc_pkg::cmd_type            cmd,
   input  logic [IDX_W-1:0]                idx,
   input  logic [2*nlmsanc_pkg::DATA_W-1:0] req_tdata,
   input  logic [nlmsanc_pkg::GAIN_W-1:0]  step_gain,
   input  logic [nlmsanc_pkg::DATA_W-1:0]  energy_floor,
   input  logic                            rsp_tready,
   output nlmsanc_pkg::sts_type            sts,
   output logic                            rsp_tvalid,
   output logic [nlmsanc_pkg::DATA_W-1:0]  rsp_tdata
);

   localparam int DW = nlmsanc_pkg::DATA_W;

   logic signed [DW-1:0] x_line_ff [MAX_TAPS];
   logic signed [DW-1:0] w_ff      [MAX_TAPS];
   logic signed [DW-1:0] d_ff;
   logic signed [2*DW-1:0] pw_ff, pw_in;
   logic [2*DW-1:0]        pe_ff, pe_in;
   logic                   prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_sh;
   logic [EN_W-1:0]        en_ff;
   logic signed [E_W-1:0]  e_ff, e_in, emag;
   logic [NUM_W-1:0]       num_ff, q_ff;
   logic [EN_W:0]          rem_ff, rem_sh;
   logic [nlmsanc_pkg::QSAT_W-1:0] q_sat;
   logic [2*DW-1:0]        plo_ff, phi_ff, plo_in, phi_in;
   logic [IDX_W-1:0]       uidx_ff;
   logic                   uneg_ff, uvld_ff;
   logic                   rsp_valid_ff;
   logic [DW-1:0]          rsp_data_ff, e_sat;
   logic signed [DW-1:0]   xv, wv;
   logic [DW-1:0]          xm;
   logic [3*DW-1:0]        p96;
   logic [3*DW-nlmsanc_pkg::UPD_SHIFT-1:0] ps;
   logic [nlmsanc_pkg::DELTA_W-1:0] dm;
   logic signed [DW+2:0]   wsum;
   logic signed [DW-1:0]   wnew;

   assign xv     = x_line_ff[idx];
   assign wv     = w_ff[idx];
   assign xm     = xv[DW-1] ? DW'(-xv) : xv;
   assign pw_in  = xv * wv;
   assign pe_in  = (2*DW)'(xm) * (2*DW)'(xm);
   assign acc_sh = acc_ff >>> nlmsanc_pkg::PROD_SHIFT;
   assign e_in   = E_W'(d_ff) - E_W'(acc_sh);
   assign emag   = e_ff[E_W-1] ? -e_ff : e_ff;
   assign rem_sh = {rem_ff[EN_W-1:0], num_ff[NUM_W-1]};
   assign q_sat  = (|q_ff[NUM_W-1:nlmsanc_pkg::QSAT_W]) ? '1 : q_ff[nlmsanc_pkg::QSAT_W-1:0];
   assign plo_in = (2*DW)'(q_sat[DW-1:0]) * (2*DW)'(xm);
   assign phi_in = (2*DW)'(q_sat[2*DW-1:DW]) * (2*DW)'(xm);

   // Saturate the wide error to the output range.
   always_comb begin
      if ((&e_ff[E_W-1:DW-1]) || !(|e_ff[E_W-1:DW-1])) e_sat = e_ff[DW-1:0];
      else if (e_ff[E_W-1]) e_sat = {1'b1, {(DW-1){1'b0}}};
      else e_sat = {1'b0, {(DW-1){1'b1}}};
   end

   // Second update stage: scale, clamp the step, apply and saturate the weight.
   always_comb begin
      p96 = {phi_ff, {DW{1'b0}}} + {{DW{1'b0}}, plo_ff};
      ps  = p96[3*DW-1:nlmsanc_pkg::UPD_SHIFT];
      if (ps > (3*DW-nlmsanc_pkg::UPD_SHIFT)'({1'b1, {(nlmsanc_pkg::DELTA_W-1){1'b0}}}))
         dm = {1'b1, {(nlmsanc_pkg::DELTA_W-1){1'b0}}};
      else
         dm = ps[nlmsanc_pkg::DELTA_W-1:0];
      if (uneg_ff) wsum = (DW+3)'(w_ff[uidx_ff]) - signed'({1'b0, dm});
      else         wsum = (DW+3)'(w_ff[uidx_ff]) + signed'({1'b0, dm});
      if ((&wsum[DW+2:DW-1]) || !(|wsum[DW+2:DW-1])) wnew = wsum[DW-1:0];
      else if (wsum[DW+2]) wnew = {1'b1, {(DW-1){1'b0}}};
      else wnew = {1'b0, {(DW-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TAPS; i++) begin
            x_line_ff[i] <= '0;
            w_ff[i]      <= '0;
         end
         prod_vld_ff  <= 1'b0;
         uvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            x_line_ff[0] <= req_tdata[2*DW-1:DW];
            for (int i = 1; i < MAX_TAPS; i++) x_line_ff[i] <= x_line_ff[i-1];
         end
         prod_vld_ff <= cmd.mac;
         uvld_ff     <= cmd.upd;
         if (uvld_ff) w_ff[uidx_ff] <= wnew;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d_ff   <= req_tdata[DW-1:0];
         acc_ff <= '0;
         en_ff  <= EN_W'(energy_floor);
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(pw_ff);
         en_ff  <= en_ff + EN_W'(pe_ff);
      end
      if (cmd.mac) begin
         pw_ff <= pw_in;
         pe_ff <= pe_in;
      end
      if (cmd.err) e_ff <= e_in;
      if (cmd.emit) begin
         rsp_data_ff <= e_sat;
         num_ff      <= NUM_W'(step_gain * emag) << nlmsanc_pkg::GAIN_SHIFT;
         rem_ff      <= '0;
         q_ff        <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (rem_sh >= {1'b0, en_ff}) begin
            rem_ff <= rem_sh - {1'b0, en_ff};
            q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
      if (cmd.upd) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         uidx_ff <= idx;
         uneg_ff <= e_ff[E_W-1] ^ xv[DW-1];
      end
   end

   assign sts.slot_free   = !rsp_valid_ff || rsp_tready;
   assign sts.energy_zero = (en_ff == '0);
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

endmodule

FILE: src/nlms_adaptive_noise_canceller_core.sv
// Top level of the NLMS adaptive noise canceller: register file and the two halves.
// The divider forms 103 quotient bits at 32 taps (the default MAX_TAPS).
// The serial divider (one quotient bit per cycle) and the two passes over the taps
// set the rate; a new word is taken only once the previous update has finished.
// The clean sample follows the filter pass, drain and error states and waits in an
// output register. Synchronous active-high reset clears weights and the delay line.
module nlms_adaptive_noise_canceller_core #(
   parameter int MAX_TAPS = nlmsanc_pkg::MAX_TAPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] desired_word, [63:32] noise_ref
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] clean_sample
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Accumulator widths grow with the number of taps so no sum can overflow.
   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int ACC_W = 2*nlmsanc_pkg::DATA_W + $clog2(MAX_TAPS) + 1;
   localparam int EN_W  = 2*nlmsanc_pkg::DATA_W - 2 + $clog2(MAX_TAPS) + 1;
   localparam int E_W   = ACC_W - nlmsanc_pkg::PROD_SHIFT + 1;
   localparam int NUM_W = nlmsanc_pkg::GAIN_W + E_W + nlmsanc_pkg::GAIN_SHIFT;

   logic [nlmsanc_pkg::TAPS_W-1:0] taps_ff;
   logic [nlmsanc_pkg::GAIN_W-1:0] gain_ff;
   logic [nlmsanc_pkg::DATA_W-1:0] floor_ff;
   logic [IDX_W-1:0]               taps_last;
   logic [IDX_W-1:0]               idx;
   nlmsanc_pkg::cmd_type           cmd;
   nlmsanc_pkg::sts_type           sts;

   // Configuration registers; writes to an unknown index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff  <= nlmsanc_pkg::TAPS_RST;
         gain_ff  <= nlmsanc_pkg::GAIN_RST;
         floor_ff <= nlmsanc_pkg::FLOOR_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            nlmsanc_pkg::CSR_TAPS:  taps_ff  <= csr_wdata[nlmsanc_pkg::TAPS_W-1:0];
            nlmsanc_pkg::CSR_GAIN:  gain_ff  <= csr_wdata[nlmsanc_pkg::GAIN_W-1:0];
            nlmsanc_pkg::CSR_FLOOR: floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Index of the last active tap: a count of zero acts as one tap, and a count
   // above the built maximum is clamped to it.
   always_comb begin
      priority if (32'(taps_ff) > MAX_TAPS) taps_last = IDX_W'(MAX_TAPS - 1);
      else if (taps_ff == '0)               taps_last = '0;
      else                                  taps_last = IDX_W'(taps_ff - 1'b1);
   end

   assign req_tready = cmd.ready;

   nlmsanc_ctrl #(
      .IDX_W (IDX_W),
      .NUM_W (NUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .taps_last  (taps_last),
      .sts        (sts),
      .cmd        (cmd),
      .idx        (idx)
   );

   nlmsanc_dp #(
      .MAX_TAPS (MAX_TAPS),
      .IDX_W    (IDX_W),
      .ACC_W    (ACC_W),
      .EN_W     (EN_W),
      .E_W      (E_W),
      .NUM_W    (NUM_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .idx          (idx),
      .req_tdata    (req_tdata),
      .step_gain    (gain_ff),
      .energy_floor (floor_ff),
      .rsp_tready   (rsp_tready),
      .sts          (sts),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata)
   );

endmodule
